### design/assert_macros.svh
// assertion macros shared by the line rasterizer rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication under synchronous active-low reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication under synchronous active-low reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/glr_pkg.sv
// shared types, codes and constants of the grid line rasterizer
// no dependencies
package glr_pkg;

    localparam int COORD_W          = 16;
    localparam int LEN_W            = 17;
    localparam int ERR_W            = 34;
    localparam int NEED_W           = 18;
    localparam int CNT_W            = 17;
    localparam int CELL_CAP_W       = 16;
    localparam int MAX_RASTER_STEPS = 65536;
    localparam int RES_DEPTH        = 3;
    localparam int IDX_W            = 2;
    localparam int IN_DATA_W        = 64;
    localparam int OUT_FIELDS_W     = 35;
    localparam int OUT_DATA_W       = 40;
    localparam int OUT_PAD_W        = OUT_DATA_W - OUT_FIELDS_W;
    localparam int APB_ADDR_W       = 4;
    localparam int APB_DATA_W       = 32;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LIMIT   = 2'd1,
        ST_NO_LINE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_COVERAGE_MODE = 2'd0,
        REG_WITH_START    = 2'd1,
        REG_WITH_END      = 2'd2,
        REG_CELL_CAP      = 2'd3
    } reg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic                  coverage_mode;
        logic                  with_start;
        logic                  with_end;
        logic [CELL_CAP_W-1:0] cell_cap;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        coverage_mode: 1'b0,
        with_start:    1'b1,
        with_end:      1'b1,
        cell_cap:      16'hFFFF
    };

    typedef struct packed {
        opcode_t opcode;
        coord_t  start_x;
        coord_t  start_y;
        coord_t  end_x;
        coord_t  end_y;
    } item_t;

    typedef struct packed {
        coord_t  cell_x;
        coord_t  cell_y;
        logic    cell_valid;
        logic    last_of_step;
        logic    line_done;
        status_t status;
    } result_t;

    // all results caused by one input beat
    typedef struct packed {
        logic [IDX_W-1:0]            count;
        result_t [RES_DEPTH-1:0]     res;
    } batch_t;

endpackage

### design/glr_cfg_regs.sv
// apb register file of the grid line rasterizer
// depends on glr_pkg
module glr_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [glr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [glr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [glr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output glr_pkg::cfg_t                   cfg
);
    import glr_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // register writes in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_COVERAGE_MODE: cfg_reg.coverage_mode <= pwdata[0];
                REG_WITH_START:    cfg_reg.with_start    <= pwdata[0];
                REG_WITH_END:      cfg_reg.with_end      <= pwdata[0];
                REG_CELL_CAP:      cfg_reg.cell_cap      <= pwdata[CELL_CAP_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_COVERAGE_MODE: prdata = APB_DATA_W'(cfg_reg.coverage_mode);
            REG_WITH_START:    prdata = APB_DATA_W'(cfg_reg.with_start);
            REG_WITH_END:      prdata = APB_DATA_W'(cfg_reg.with_end);
            REG_CELL_CAP:      prdata = APB_DATA_W'(cfg_reg.cell_cap);
            default:           prdata = '0;
        endcase
    end

endmodule

### design/glr_step_engine.sv
// line state and single-pass step logic: one input beat in, one batch of results out
// depends on glr_pkg and assert_macros.svh
`include "assert_macros.svh"
module glr_step_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            take,
    input  glr_pkg::item_t  item,
    input  glr_pkg::cfg_t   cfg,
    output glr_pkg::batch_t batch
);
    import glr_pkg::*;

    // line state
    logic             line_active_reg, line_active_next;
    logic             first_pending_reg, first_pending_next;
    logic             line_mode_reg, line_mode_next;
    logic             x_major_reg, x_major_next;
    logic             sx_neg_reg, sx_neg_next;
    logic             sy_neg_reg, sy_neg_next;
    coord_t           pos_x_reg, pos_x_next;
    coord_t           pos_y_reg, pos_y_next;
    coord_t           origin_x_reg, origin_x_next;
    coord_t           origin_y_reg, origin_y_next;
    coord_t           target_x_reg, target_x_next;
    coord_t           target_y_reg, target_y_next;
    logic [LEN_W-1:0] major_len_reg, major_len_next;
    logic [LEN_W-1:0] minor_len_reg, minor_len_next;
    logic [LEN_W-1:0] step_index_reg, step_index_next;
    logic [LEN_W-1:0] minor_rem_reg, minor_rem_next;
    // running cross products next_x_odd*dy and next_y_odd*dx
    logic [ERR_W-1:0] lhs_reg, lhs_next;
    logic [ERR_W-1:0] rhs_reg, rhs_next;
    logic [CNT_W-1:0] cells_reg, cells_next;

    // load helpers
    logic signed [LEN_W-1:0] diff_x, diff_y;
    logic [LEN_W-1:0]        ld_dx, ld_dy, ld_major;
    logic [NEED_W-1:0]       ld_need;
    logic                    ld_x_major, ld_empty, ld_too_long;

    // walk helpers
    coord_t            nx, ny, base_cur, base_up, near_cell;
    logic [LEN_W-1:0]  dx_cur, dy_cur;
    logic [NEED_W-1:0] dbl, major_ext, rem_sum;
    logic              near_up, half_tie, rem_wrap;

    // candidate cells and walk update
    coord_t           cand_x [RES_DEPTH];
    coord_t           cand_y [RES_DEPTH];
    logic             want   [RES_DEPTH];
    coord_t           wk_pos_x, wk_pos_y;
    logic [LEN_W-1:0] wk_step_index, wk_rem;
    logic [ERR_W-1:0] wk_lhs, wk_rhs;
    logic             walk_done;

    // emission results
    coord_t           keep_x [RES_DEPTH];
    coord_t           keep_y [RES_DEPTH];
    logic [IDX_W-1:0] em_n;
    logic [CNT_W-1:0] em_cnt, limit_at;
    logic             em_lim, distinct;

    // batch description
    logic [IDX_W-1:0] res_cells, res_total;
    logic             res_done;
    status_t          res_status;

    // endpoint deltas of a load
    always_comb begin
        diff_x      = LEN_W'(item.end_x) - LEN_W'(item.start_x);
        diff_y      = LEN_W'(item.end_y) - LEN_W'(item.start_y);
        ld_dx       = diff_x[LEN_W-1] ? LEN_W'(-diff_x) : LEN_W'(diff_x);
        ld_dy       = diff_y[LEN_W-1] ? LEN_W'(-diff_y) : LEN_W'(diff_y);
        ld_x_major  = ld_dx >= ld_dy;
        ld_major    = ld_x_major ? ld_dx : ld_dy;
        ld_need     = cfg.coverage_mode ? NEED_W'(ld_dx) + NEED_W'(ld_dy) + NEED_W'(1)
                                        : NEED_W'(ld_major) + NEED_W'(1);
        ld_too_long = ld_need > NEED_W'(MAX_RASTER_STEPS);
        ld_empty    = (ld_dx == '0) && (ld_dy == '0) && !cfg.with_start
                      && !cfg.with_end;
    end

    // neighbor coordinates and center-mode error terms
    always_comb begin
        nx        = sx_neg_reg ? pos_x_reg - 16'sd1 : pos_x_reg + 16'sd1;
        ny        = sy_neg_reg ? pos_y_reg - 16'sd1 : pos_y_reg + 16'sd1;
        dx_cur    = x_major_reg ? major_len_reg : minor_len_reg;
        dy_cur    = x_major_reg ? minor_len_reg : major_len_reg;
        base_cur  = x_major_reg ? pos_y_reg : pos_x_reg;
        base_up   = x_major_reg ? ny : nx;
        dbl       = {minor_rem_reg, 1'b0};
        major_ext = NEED_W'(major_len_reg);
        near_up   = dbl > major_ext;
        half_tie  = (major_len_reg != '0) && (dbl == major_ext);
        near_cell = near_up ? base_up : base_cur;
        rem_sum   = NEED_W'(minor_rem_reg) + NEED_W'(minor_len_reg);
        rem_wrap  = rem_sum >= major_ext;
    end

    // candidate cells of one step and the walk update
    always_comb begin
        for (int k = 0; k < RES_DEPTH; k++) begin
            cand_x[k] = pos_x_reg;
            cand_y[k] = pos_y_reg;
            want[k]   = 1'b0;
        end
        wk_pos_x      = pos_x_reg;
        wk_pos_y      = pos_y_reg;
        wk_step_index = step_index_reg;
        wk_rem        = minor_rem_reg;
        wk_lhs        = lhs_reg;
        wk_rhs        = rhs_reg;
        walk_done     = 1'b0;
        if (!line_mode_reg) begin
            // center cells: nearest minor cell, both on a half tie
            want[0] = 1'b1;
            want[1] = half_tie;
            if (x_major_reg) begin
                cand_y[0] = near_cell;
                cand_y[1] = ny;
            end else begin
                cand_x[0] = near_cell;
                cand_x[1] = nx;
            end
            walk_done = step_index_reg >= major_len_reg;
            if (!walk_done) begin
                wk_step_index = step_index_reg + LEN_W'(1);
                wk_rem        = rem_wrap ? LEN_W'(rem_sum - major_ext) : LEN_W'(rem_sum);
                if (x_major_reg) begin
                    wk_pos_x = nx;
                    if (rem_wrap) wk_pos_y = ny;
                end else begin
                    wk_pos_y = ny;
                    if (rem_wrap) wk_pos_x = nx;
                end
            end
        end else begin
            // supercover cells
            want[0] = 1'b1;
            if (first_pending_reg) begin
                wk_pos_x = pos_x_reg;
            end else if ((pos_x_reg == target_x_reg) || (lhs_reg > rhs_reg
                         && pos_y_reg != target_y_reg)) begin
                wk_pos_y  = ny;
                wk_rhs    = rhs_reg + ERR_W'({dx_cur, 1'b0});
                cand_y[0] = ny;
            end else if ((pos_y_reg == target_y_reg) || (lhs_reg < rhs_reg)) begin
                wk_pos_x  = nx;
                wk_lhs    = lhs_reg + ERR_W'({dy_cur, 1'b0});
                cand_x[0] = nx;
            end else begin
                // exact corner: both side cells, then the diagonal
                want[1]   = 1'b1;
                want[2]   = 1'b1;
                cand_x[0] = nx;
                cand_y[1] = ny;
                cand_x[2] = nx;
                cand_y[2] = ny;
                wk_pos_x  = nx;
                wk_pos_y  = ny;
                wk_lhs    = lhs_reg + ERR_W'({dy_cur, 1'b0});
                wk_rhs    = rhs_reg + ERR_W'({dx_cur, 1'b0});
            end
            walk_done = (wk_pos_x == target_x_reg) && (wk_pos_y == target_y_reg);
        end
    end

    // endpoint filtering and cell limit, candidates in order
    always_comb begin
        logic drop;
        distinct = (origin_x_reg != target_x_reg) || (origin_y_reg != target_y_reg);
        limit_at = CNT_W'(cfg.cell_cap) + CNT_W'(2);
        em_cnt   = cells_reg;
        em_lim   = 1'b0;
        em_n     = '0;
        drop     = 1'b0;
        for (int k = 0; k < RES_DEPTH; k++) begin
            keep_x[k] = '0;
            keep_y[k] = '0;
        end
        for (int k = 0; k < RES_DEPTH; k++) begin
            drop = distinct && ((!cfg.with_start && cand_x[k] == origin_x_reg
                                 && cand_y[k] == origin_y_reg)
                             || (!cfg.with_end && cand_x[k] == target_x_reg
                                 && cand_y[k] == target_y_reg));
            if (want[k] && !drop && !em_lim) begin
                if (em_cnt >= limit_at) begin
                    em_lim = 1'b1;
                end else begin
                    keep_x[em_n] = cand_x[k];
                    keep_y[em_n] = cand_y[k];
                    em_n         = em_n + IDX_W'(1);
                    em_cnt       = em_cnt + CNT_W'(1);
                end
            end
        end
    end

    // next state and outcome of the beat
    always_comb begin
        line_active_next   = line_active_reg;
        first_pending_next = first_pending_reg;
        line_mode_next     = line_mode_reg;
        x_major_next       = x_major_reg;
        sx_neg_next        = sx_neg_reg;
        sy_neg_next        = sy_neg_reg;
        pos_x_next         = pos_x_reg;
        pos_y_next         = pos_y_reg;
        origin_x_next      = origin_x_reg;
        origin_y_next      = origin_y_reg;
        target_x_next      = target_x_reg;
        target_y_next      = target_y_reg;
        major_len_next     = major_len_reg;
        minor_len_next     = minor_len_reg;
        step_index_next    = step_index_reg;
        minor_rem_next     = minor_rem_reg;
        lhs_next           = lhs_reg;
        rhs_next           = rhs_reg;
        cells_next         = cells_reg;
        res_cells          = '0;
        res_done           = 1'b1;
        res_status         = ST_NO_LINE;
        if (item.opcode == OP_LOAD) begin
            origin_x_next      = item.start_x;
            origin_y_next      = item.start_y;
            target_x_next      = item.end_x;
            target_y_next      = item.end_y;
            pos_x_next         = item.start_x;
            pos_y_next         = item.start_y;
            line_mode_next     = cfg.coverage_mode;
            x_major_next       = ld_x_major;
            major_len_next     = ld_major;
            minor_len_next     = ld_x_major ? ld_dy : ld_dx;
            sx_neg_next        = item.end_x < item.start_x;
            sy_neg_next        = item.end_y < item.start_y;
            step_index_next    = '0;
            minor_rem_next     = '0;
            lhs_next           = ERR_W'(ld_dy);
            rhs_next           = ERR_W'(ld_dx);
            cells_next         = '0;
            first_pending_next = 1'b1;
            line_active_next   = 1'b0;
            if (ld_empty) begin
                res_status = ST_OK;
            end else if (ld_too_long) begin
                first_pending_next = 1'b0;
                res_status         = ST_LIMIT;
            end else begin
                line_active_next = 1'b1;
                res_done         = 1'b0;
                res_status       = ST_OK;
            end
        end else if (line_active_reg) begin
            pos_x_next         = wk_pos_x;
            pos_y_next         = wk_pos_y;
            step_index_next    = wk_step_index;
            minor_rem_next     = wk_rem;
            lhs_next           = wk_lhs;
            rhs_next           = wk_rhs;
            cells_next         = em_cnt;
            first_pending_next = 1'b0;
            res_cells          = em_n;
            res_done           = em_lim || walk_done;
            res_status         = em_lim ? ST_LIMIT : ST_OK;
            line_active_next   = !(em_lim || walk_done);
        end
    end

    // pack the batch: kept cells, then an empty result when none or on limit
    always_comb begin
        res_total = res_cells
                    + IDX_W'((res_cells == '0) || (res_status == ST_LIMIT));
        batch.count = res_total;
        for (int k = 0; k < RES_DEPTH; k++) begin
            batch.res[k].cell_valid   = IDX_W'(k) < res_cells;
            batch.res[k].cell_x       = (IDX_W'(k) < res_cells) ? keep_x[k] : '0;
            batch.res[k].cell_y       = (IDX_W'(k) < res_cells) ? keep_y[k] : '0;
            batch.res[k].last_of_step = IDX_W'(k) == res_total - IDX_W'(1);
            batch.res[k].line_done    = res_done;
            batch.res[k].status       = res_status;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg   <= 1'b0;
            first_pending_reg <= 1'b0;
        end else if (take) begin
            line_active_reg   <= line_active_next;
            first_pending_reg <= first_pending_next;
        end
    end

    // line geometry and walk registers
    always_ff @(posedge aclk) begin
        if (take) begin
            line_mode_reg  <= line_mode_next;
            x_major_reg    <= x_major_next;
            sx_neg_reg     <= sx_neg_next;
            sy_neg_reg     <= sy_neg_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            origin_x_reg   <= origin_x_next;
            origin_y_reg   <= origin_y_next;
            target_x_reg   <= target_x_next;
            target_y_reg   <= target_y_next;
            major_len_reg  <= major_len_next;
            minor_len_reg  <= minor_len_next;
            step_index_reg <= step_index_next;
            minor_rem_reg  <= minor_rem_next;
            lhs_reg        <= lhs_next;
            rhs_reg        <= rhs_next;
            cells_reg      <= cells_next;
        end
    end

    `ASSERT_IMPL(a_batch_nonempty, aclk, aresetn, take, batch.count != '0, "empty result batch")
    `ASSERT_IMPL(a_center_index, aclk, aresetn, line_active_reg && !line_mode_reg, step_index_reg <= major_len_reg, "center step index past major length")
    `ASSERT_IMPL(a_cover_not_at_end, aclk, aresetn, line_active_reg && line_mode_reg && !first_pending_reg, !(pos_x_reg == target_x_reg && pos_y_reg == target_y_reg), "supercover line still active at its end cell")

endmodule

### design/glr_result_buf.sv
// result register: holds one batch and hands it out one beat per cycle while m_tready is high
// depends on glr_pkg and assert_macros.svh
`include "assert_macros.svh"
module glr_result_buf (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            batch_load,
    input  glr_pkg::batch_t                 batch,
    output logic                            load_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cell_x [15:0], cell_y [31:16], line_done [32], status [34:33], zero pad
    output logic [glr_pkg::OUT_DATA_W-1:0]  m_tdata,
    // cell_valid
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import glr_pkg::*;

    result_t          entries_reg [RES_DEPTH];
    logic [IDX_W-1:0] count_reg, rd_idx_reg;
    result_t          cur;
    logic             pop, last_pop;

    assign cur        = entries_reg[rd_idx_reg];
    assign m_tvalid   = count_reg != '0;
    assign pop        = m_tvalid && m_tready;
    assign last_pop   = pop && (rd_idx_reg == count_reg - IDX_W'(1));
    assign load_ready = (count_reg == '0) || last_pop;

    assign m_tdata = {{OUT_PAD_W{1'b0}}, cur.status, cur.line_done, cur.cell_y, cur.cell_x};
    assign m_tuser = cur.cell_valid;
    assign m_tlast = cur.last_of_step;

    // fill and drain counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            rd_idx_reg <= '0;
        end else if (batch_load) begin
            count_reg  <= batch.count;
            rd_idx_reg <= '0;
        end else if (last_pop) begin
            count_reg  <= '0;
            rd_idx_reg <= '0;
        end else if (pop) begin
            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
    end

    // batch payload
    always_ff @(posedge aclk) begin
        if (batch_load) begin
            for (int k = 0; k < RES_DEPTH; k++) begin
                entries_reg[k] <= batch.res[k];
            end
        end
    end

    `ASSERT_IMPL(a_rd_in_range, aclk, aresetn, count_reg != '0, rd_idx_reg < count_reg, "read index beyond batch")
    `ASSERT_IMPL(a_last_on_final, aclk, aresetn, m_tvalid, m_tlast == (rd_idx_reg == count_reg - IDX_W'(1)), "tlast not on final beat of batch")
    `ASSERT_NEXT(a_load_shows, aclk, aresetn, batch_load, m_tvalid, "loaded batch not presented")

endmodule

### design/grid_line_rasterizer_unit.sv
// Grid line rasterizer, top level: input register, step engine, result register, apb regs.
// An accepted beat is held in the input register, then its batch in the result register.
// Throughput: one input beat per cycle while the result register can take a batch; a beat
// holds it until its results (1 to 3) are taken, so supercover corner steps give up to 3 beats.
// Reset: synchronous aresetn (active low) ends any line, empties both registers and
// returns the config registers to their reset values.
module grid_line_rasterizer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // start_x [15:0], start_y [31:16], end_x [47:32], end_y [63:48]
    input  logic [glr_pkg::IN_DATA_W-1:0]   s_tdata,
    // opcode
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cell_x [15:0], cell_y [31:16], line_done [32], status [34:33], zero pad
    output logic [glr_pkg::OUT_DATA_W-1:0]  m_tdata,
    // cell_valid
    output logic                            m_tuser,
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [glr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [glr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [glr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import glr_pkg::*;

    cfg_t   cfg;
    item_t  in_item, in_item_reg;
    logic   in_valid_reg;
    logic   load_ready, take;
    batch_t batch;

    // unpack the input beat
    assign in_item.opcode  = opcode_t'(s_tuser);
    assign in_item.start_x = s_tdata[15:0];
    assign in_item.start_y = s_tdata[31:16];
    assign in_item.end_x   = s_tdata[47:32];
    assign in_item.end_y   = s_tdata[63:48];

    assign take     = in_valid_reg && load_ready;
    assign s_tready = !in_valid_reg || load_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item;
        end
    end

    glr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    glr_step_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (in_item_reg),
        .cfg     (cfg),
        .batch   (batch)
    );

    glr_result_buf u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .batch_load (take),
        .batch      (batch),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

### tb/grid_line_rasterizer_unit_tb.sv
// self-checking testbench for grid_line_rasterizer_unit: bursty line loads and steps in,
// randomly stalled cell beats out, each beat checked against an in-bench line walker
// depends on glr_pkg and the rtl of grid_line_rasterizer_unit
`timescale 1ns / 1ps

module grid_line_rasterizer_unit_tb;
    import glr_pkg::*;

    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 30;
    localparam int MAX_REPORTS    = 10;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input stream
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;

    // result stream
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // register port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    grid_line_rasterizer_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stimulus and expectation stores
    item_t       pending_items[$];
    result_t     cell_q[$];
    result_t     step_cells[$];
    int unsigned queued_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned err_cnt      = 0;

    // line walker state, mirrors the block
    cfg_t        cfg           = CFG_RESET;
    logic        line_on       = 1'b0;
    logic        first_pending = 1'b0;
    logic        x_major       = 1'b0;
    logic        supercover    = 1'b0;
    logic        neg_x         = 1'b0;
    logic        neg_y         = 1'b0;
    logic        hit_limit     = 1'b0;
    int          pos_x = 0, pos_y = 0, org_x = 0, org_y = 0, tgt_x = 0, tgt_y = 0;
    int unsigned major_len = 0, minor_len = 0, step_idx = 0;
    int unsigned minor_quo = 0, minor_rem = 0, odd_x = 1, odd_y = 1, cells_out = 0;

    function automatic int unsigned abs_gap(int a, int b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // keep a cell unless it is a dropped endpoint or past the cell budget
    function automatic void emit_cell(int x, int y);
        result_t r;
        logic    distinct;
        distinct = (org_x != tgt_x) || (org_y != tgt_y);
        if (hit_limit)
            return;
        if (distinct && !cfg.with_start && x == org_x && y == org_y)
            return;
        if (distinct && !cfg.with_end && x == tgt_x && y == tgt_y)
            return;
        if (cells_out >= cfg.cell_cap + 32'd2) begin
            hit_limit = 1'b1;
            return;
        end
        r            = '0;
        r.cell_x     = x[15:0];
        r.cell_y     = y[15:0];
        r.cell_valid = 1'b1;
        step_cells.insert(step_cells.size(), r);
        cells_out++;
    endfunction

    // stamp outcome on the beats of one input and move them to the expected store
    function automatic void close_step(logic done, status_t st);
        result_t blank;
        blank = '0;
        if (step_cells.size() == 0 || st == ST_LIMIT)
            step_cells.insert(step_cells.size(), blank);
        foreach (step_cells[k]) begin
            step_cells[k].line_done    = done;
            step_cells[k].status       = st;
            step_cells[k].last_of_step = (k == step_cells.size() - 1);
            cell_q.insert(cell_q.size(), step_cells[k]);
        end
        step_cells.delete();
    endfunction

    // one major-axis step of the nearest-cell walk
    function automatic bit center_advance();
        int          sx, sy, smaj, smin, maj, base, near_c;
        int unsigned dbl;
        sx     = neg_x ? -1 : 1;
        sy     = neg_y ? -1 : 1;
        smaj   = x_major ? sx : sy;
        smin   = x_major ? sy : sx;
        maj    = (x_major ? org_x : org_y) + smaj * int'(step_idx);
        base   = (x_major ? org_y : org_x) + smin * int'(minor_quo);
        dbl    = minor_rem * 2;
        near_c = base + ((dbl > major_len) ? smin : 0);
        first_pending = 1'b0;
        if (x_major) emit_cell(maj, near_c);
        else emit_cell(near_c, maj);
        // exact half: the second minor cell as well
        if (major_len != 0 && dbl == major_len) begin
            if (x_major) emit_cell(maj, base + smin);
            else emit_cell(base + smin, maj);
        end
        if (step_idx >= major_len)
            return 1'b1;
        minor_rem += minor_len;
        if (minor_rem >= major_len) begin
            minor_rem -= major_len;
            minor_quo++;
        end
        step_idx++;
        return 1'b0;
    endfunction

    // one move of the supercover walk, corner tie gives three cells
    function automatic bit cover_advance();
        int              sx, sy;
        longint unsigned lhs, rhs;
        sx = neg_x ? -1 : 1;
        sy = neg_y ? -1 : 1;
        if (first_pending) begin
            first_pending = 1'b0;
            emit_cell(pos_x, pos_y);
        end else if (pos_x == tgt_x) begin
            pos_y += sy;
            odd_y += 2;
            emit_cell(pos_x, pos_y);
        end else if (pos_y == tgt_y) begin
            pos_x += sx;
            odd_x += 2;
            emit_cell(pos_x, pos_y);
        end else begin
            lhs = 64'(odd_x) * 64'(abs_gap(tgt_y, org_y));
            rhs = 64'(odd_y) * 64'(abs_gap(tgt_x, org_x));
            if (lhs < rhs) begin
                pos_x += sx;
                odd_x += 2;
                emit_cell(pos_x, pos_y);
            end else if (lhs > rhs) begin
                pos_y += sy;
                odd_y += 2;
                emit_cell(pos_x, pos_y);
            end else begin
                emit_cell(pos_x + sx, pos_y);
                emit_cell(pos_x, pos_y + sy);
                pos_x += sx;
                pos_y += sy;
                odd_x += 2;
                odd_y += 2;
                emit_cell(pos_x, pos_y);
            end
        end
        return (pos_x == tgt_x) && (pos_y == tgt_y);
    endfunction

    // expected beats of one accepted input
    function automatic void predict_cells(item_t it);
        int unsigned dx, dy, need;
        bit          done;
        hit_limit = 1'b0;
        if (it.opcode == OP_LOAD) begin
            org_x = it.start_x;
            org_y = it.start_y;
            tgt_x = it.end_x;
            tgt_y = it.end_y;
            pos_x = org_x;
            pos_y = org_y;
            dx = abs_gap(tgt_x, org_x);
            dy = abs_gap(tgt_y, org_y);
            supercover = cfg.coverage_mode;
            x_major    = dx >= dy;
            major_len  = x_major ? dx : dy;
            minor_len  = x_major ? dy : dx;
            neg_x      = tgt_x < org_x;
            neg_y      = tgt_y < org_y;
            step_idx   = 0;
            minor_quo  = 0;
            minor_rem  = 0;
            odd_x      = 1;
            odd_y      = 1;
            cells_out  = 0;
            first_pending = 1'b1;
            line_on       = 1'b0;
            if (dx == 0 && dy == 0 && !cfg.with_start && !cfg.with_end) begin
                close_step(1'b1, ST_OK);
            end else begin
                need = supercover ? dx + dy + 1 : major_len + 1;
                if (need > MAX_RASTER_STEPS) begin
                    first_pending = 1'b0;
                    close_step(1'b1, ST_LIMIT);
                end else begin
                    line_on = 1'b1;
                    close_step(1'b0, ST_OK);
                end
            end
        end else if (!line_on) begin
            close_step(1'b1, ST_NO_LINE);
        end else begin
            done = supercover ? cover_advance() : center_advance();
            if (hit_limit) begin
                line_on = 1'b0;
                close_step(1'b1, ST_LIMIT);
            end else begin
                if (done)
                    line_on = 1'b0;
                close_step(done, ST_OK);
            end
        end
    endfunction

    // input driver: bursts with random gaps
    item_t       cur_item   = '0;
    item_t       next_item;
    logic        in_taken   = 1'b0;
    int unsigned burst_left = 4;
    int unsigned gap_left   = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                next_item = pending_items.pop_front();
                cur_item  <= next_item;
                s_tvalid  <= 1'b1;
                s_tuser   <= next_item.opcode;
                s_tdata   <= {next_item.end_y, next_item.end_x,
                              next_item.start_y, next_item.start_x};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // input beat accepted: predict its cells
    always @(posedge aclk) begin
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            predict_cells(cur_item);
            accepted_cnt++;
        end
    end

    // receiver stall pattern, rotated each cycle and reshuffled when stall_age runs down to zero
    logic [15:0] stall_pat = 16'hFFFF;
    int unsigned stall_age = 0;

    always @(negedge aclk) begin
        if (stall_age == 0) begin
            stall_age <= 47;
            if ($urandom_range(0, 3) == 0) stall_pat <= 16'hFFFF;
            else stall_pat <= 16'($urandom) | 16'h0001;
        end else begin
            stall_age <= stall_age - 1;
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
        end
        m_tready <= stall_pat[0];
    end

    // result monitor
    result_t got_cell;
    result_t exp_cell;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_cell.cell_x       = m_tdata[15:0];
            got_cell.cell_y       = m_tdata[31:16];
            got_cell.line_done    = m_tdata[32];
            got_cell.status       = status_t'(m_tdata[34:33]);
            got_cell.cell_valid   = m_tuser;
            got_cell.last_of_step = m_tlast;
            if (cell_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected beat x=%0d y=%0d v=%0b last=%0b done=%0b st=%0d",
                             $time, got_cell.cell_x, got_cell.cell_y, got_cell.cell_valid,
                             got_cell.last_of_step, got_cell.line_done, got_cell.status);
            end else begin
                exp_cell = cell_q.pop_front();
                if (got_cell !== exp_cell || m_tdata[OUT_DATA_W-1:OUT_FIELDS_W] !== '0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display({"%0t: mismatch exp x=%0d y=%0d v=%0b last=%0b done=%0b st=%0d",
                                  " / got x=%0d y=%0d v=%0b last=%0b done=%0b st=%0d pad=%h"},
                                 $time, exp_cell.cell_x, exp_cell.cell_y, exp_cell.cell_valid,
                                 exp_cell.last_of_step, exp_cell.line_done, exp_cell.status,
                                 got_cell.cell_x, got_cell.cell_y, got_cell.cell_valid,
                                 got_cell.last_of_step, got_cell.line_done, got_cell.status,
                                 m_tdata[OUT_DATA_W-1:OUT_FIELDS_W]);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    int unsigned idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // register write: setup then access, shadow copy updated at the write edge
    task automatic apb_write(reg_idx_t idx, logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_COVERAGE_MODE: cfg.coverage_mode = val[0];
            REG_WITH_START:    cfg.with_start    = val[0];
            REG_WITH_END:      cfg.with_end      = val[0];
            REG_CELL_CAP:      cfg.cell_cap      = val[15:0];
            default:           cfg               = cfg;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic mode, logic inc_start, logic inc_end, logic [15:0] max_c);
        apb_write(REG_COVERAGE_MODE, {31'd0, mode});
        apb_write(REG_WITH_START, {31'd0, inc_start});
        apb_write(REG_WITH_END, {31'd0, inc_end});
        apb_write(REG_CELL_CAP, {16'd0, max_c});
        @(posedge aclk);
    endtask

    task automatic push_item(item_t it);
        pending_items.insert(pending_items.size(), it);
        queued_cnt++;
    endtask

    task automatic push_load(int x0, int y0, int x1, int y1);
        item_t it;
        it.opcode  = OP_LOAD;
        it.start_x = x0[15:0];
        it.start_y = y0[15:0];
        it.end_x   = x1[15:0];
        it.end_y   = y1[15:0];
        push_item(it);
    endtask

    // step beats carry random junk in the coordinate fields
    task automatic push_step();
        item_t it;
        it.opcode  = OP_STEP;
        it.start_x = 16'($urandom);
        it.start_y = 16'($urandom);
        it.end_x   = 16'($urandom);
        it.end_y   = 16'($urandom);
        push_item(it);
    endtask

    // mostly a short line walked to its end, sometimes cut short, stray or long
    task automatic queue_random_seq();
        item_t       it;
        int unsigned kind, dx, dy, est, steps;
        kind       = $urandom_range(0, 19);
        it.opcode  = OP_LOAD;
        it.start_x = 16'($urandom);
        it.start_y = 16'($urandom);
        if (kind < 2) begin
            push_step();
            return;
        end
        if (kind == 2) begin
            it.end_x = 16'($urandom);
            it.end_y = 16'($urandom);
        end else if (kind == 3) begin
            it.end_x = it.start_x;
            it.end_y = it.start_y;
        end else begin
            it.end_x = it.start_x + coord_t'($urandom_range(0, 16) - 8);
            it.end_y = it.start_y + coord_t'($urandom_range(0, 16) - 8);
        end
        push_item(it);
        dx    = abs_gap(it.end_x, it.start_x);
        dy    = abs_gap(it.end_y, it.start_y);
        est   = cfg.coverage_mode ? dx + dy + 1 : ((dx >= dy) ? dx : dy) + 1;
        steps = est + $urandom_range(0, 1);
        // long lines, including short offsets that wrapped, are only started
        if (kind == 2 || est > 24) steps = $urandom_range(0, 4);
        else if ($urandom_range(0, 7) == 0) steps = $urandom_range(0, est);
        repeat (steps) push_step();
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (accepted_cnt != queued_cnt || cell_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    logic [15:0] max_pick;
    int unsigned phase_base;

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config: center walk, both endpoints, no practical cell budget
        push_step();                                  // step with no line
        push_load(0, 0, 4, 2);                        // half tie on the minor axis
        repeat (5) push_step();
        push_load(-32768, -32768, 32767, 32767);      // longest center line still allowed
        push_step();
        push_load(3, -3, 3, -3);                      // reload with a single point
        push_step();
        push_step();
        wait_idle();

        // supercover, both endpoints dropped
        set_config(1'b1, 1'b0, 1'b0, 16'hFFFF);
        push_load(2, 2, 2, 2);                        // empty line
        push_load(-32768, 0, 32767, 1);               // too long for supercover
        push_load(0, 0, 2, -2);                       // corner ties, start and end dropped
        repeat (3) push_step();
        wait_idle();

        // supercover with a cell budget of 1: limit inside a corner tie
        set_config(1'b1, 1'b1, 1'b1, 16'd1);
        push_load(0, 0, -3, 3);
        repeat (3) push_step();
        wait_idle();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: max_pick = 16'hFFFF;
                1: max_pick = 16'd1;
                2: max_pick = 16'($urandom_range(2, 6));
                3: max_pick = 16'hFFFF;
                4: max_pick = 16'd2;
                default: max_pick = 16'($urandom_range(1, 65535));
            endcase
            set_config(ph[0], 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), max_pick);
            phase_base = queued_cnt;
            while (queued_cnt - phase_base < PHASE_ITEMS)
                queue_random_seq();
            wait_idle();
        end

        if (err_cnt == 0 && cell_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/glr_pkg.sv
design/glr_cfg_regs.sv
design/glr_step_engine.sv
design/glr_result_buf.sv
design/grid_line_rasterizer_unit.sv
tb/grid_line_rasterizer_unit_tb.sv
